// File: rtl/core/agsfi_pkg.sv
// ----------------------------------------------------------------------------
// agsfi_pkg
// Types, codes and constants shared by the smoothstep fade-in gain stage.
// ----------------------------------------------------------------------------
package agsfi_pkg;

    localparam int SMP_W     = 16;
    localparam int GAIN_W    = 12;
    localparam int FLEN_W    = 16;
    localparam int X_W       = 16;
    localparam int FADE_W    = X_W + 1;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MAG_W     = SMP_W + GAIN_W;
    localparam int P_W       = MAG_W + FADE_W;
    localparam int RND_SHIFT = 24;
    localparam int R_W       = P_W - RND_SHIFT;
    localparam int DIV_STEPS = X_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [2:0] OP_SAMPLE   = 3'd0;
    localparam logic [2:0] OP_INIT     = 3'd1;
    localparam logic [2:0] OP_RESUME   = 3'd2;
    localparam logic [2:0] OP_PAUSE    = 3'd3;
    localparam logic [2:0] OP_SHUTDOWN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLEN = 2'd1;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = 12'd768;
    localparam logic [FLEN_W-1:0]  FLEN_RST  = 16'd5292;
    localparam logic [FADE_W-1:0]  FADE_ONE  = 17'h10000;
    localparam logic [MUL_B_W-1:0] POLY_K    = 18'd196608;
    localparam logic [P_W-1:0]     RND_HALF  = P_W'(1) << (RND_SHIFT - 1);
    localparam logic [R_W-1:0]     POS_LIM   = R_W'(32767);
    localparam logic [R_W-1:0]     NEG_LIM   = R_W'(32768);
    localparam logic [SMP_W-1:0]   SMP_MAX   = 16'h7FFF;
    localparam logic [SMP_W-1:0]   SMP_MIN   = 16'h8000;

    typedef struct packed {
        logic [2:0]              opcode;
        logic signed [SMP_W-1:0] sample_in;
        logic                    last_in;
    } agsfi_in_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    clipped;
        logic                    last_out;
    } agsfi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_POLY,
        ST_MG,
        ST_MF,
        ST_OUT
    } agsfi_state_t;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_CAPTURE,
        DP_DIV,
        DP_SQ,
        DP_POLY,
        DP_MG,
        DP_MF,
        DP_OUT
    } agsfi_dp_op_t;

    typedef struct packed {
        agsfi_dp_op_t op;
        logic         rem_load;
        logic         rem_clear;
    } agsfi_cmd_t;

    typedef struct packed {
        logic fade_active;
        logic out_full;
    } agsfi_stat_t;

endpackage

// File: rtl/core/audio_gain_smoothstep_fade_in_top.sv
// ----------------------------------------------------------------------------
// audio_gain_smoothstep_fade_in_top
// Smoothstep fade-in gain stage for signed 16-bit audio with saturation.
//
//   channel  | ports                                      | direction
//   ---------+--------------------------------------------+----------
//   input    | s_valid, s_ready, s_payload                | in
//   result   | m_valid, m_ready, m_payload                | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// A sample during a fade passes capture, 16 divider steps, 4 multiplies and
// output; a sample without a fade skips the divider, square and polynomial.
// Events act in idle; the 16-step restoring divider dominates a faded sample.
// Reset clears run, suspend and fade count and loads the register defaults.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits at the output step.
// ----------------------------------------------------------------------------
module audio_gain_smoothstep_fade_in_top import agsfi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  agsfi_in_t            s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output agsfi_out_t           m_payload,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    agsfi_cmd_t  cmd;
    agsfi_stat_t stat;

    assign cfg_ready = 1'b1;

    agsfi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_payload.opcode),
        .stat    (stat),
        .cmd     (cmd)
    );

    agsfi_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_payload (s_payload),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// File: rtl/core/agsfi_dp.sv
// ----------------------------------------------------------------------------
// agsfi_dp
// Datapath: registers, fade counter, restoring divider and shared multiplier.
// ----------------------------------------------------------------------------
module agsfi_dp import agsfi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  agsfi_cmd_t           cmd,
    output agsfi_stat_t          stat,
    input  agsfi_in_t            s_payload,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output agsfi_out_t           m_payload
);

    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [FLEN_W-1:0] flen_reg, flen_next;
    logic [FLEN_W-1:0] rem_reg, rem_next;
    logic [SMP_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              last_reg, last_next;
    logic [FLEN_W-1:0] div_reg, div_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [FADE_W-1:0] fade_reg, fade_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              m_valid_reg, m_valid_next;
    agsfi_out_t        m_data_reg, m_data_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [FLEN_W:0]    div_shl;
    logic               div_ge;
    logic [P_W-1:0]     rnd_sum;
    logic [R_W-1:0]     r_mag;
    logic [SMP_W-1:0]   raw;
    logic               raw_neg;

    assign stat.fade_active = (rem_reg != '0) && (flen_reg != '0);
    assign stat.out_full    = m_valid_reg && !m_ready;

    assign raw     = s_payload.sample_in;
    assign raw_neg = raw[SMP_W-1];

    assign div_shl = {div_reg, 1'b0};
    assign div_ge  = div_shl >= {1'b0, flen_reg};

    assign rnd_sum = prod_reg[P_W-1:0] + RND_HALF;
    assign r_mag   = rnd_sum[P_W-1:RND_SHIFT];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_SQ: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(x_reg);
            end
            DP_POLY: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = POLY_K - {1'b0, x_reg, 1'b0};
            end
            DP_MG: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            DP_MF: begin
                mul_a = MUL_A_W'(prod_reg[MAG_W-1:0]);
                mul_b = MUL_B_W'(fade_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        gain_next    = gain_reg;
        flen_next    = flen_reg;
        rem_next     = rem_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        last_next    = last_reg;
        div_next     = div_reg;
        x_next       = x_reg;
        fade_next    = fade_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cfg_valid) begin
            if (cfg_index == REG_GAIN) begin
                gain_next = cfg_data[GAIN_W-1:0];
            end else if (cfg_index == REG_FLEN) begin
                flen_next = cfg_data[FLEN_W-1:0];
            end
        end

        if (cmd.rem_load) begin
            rem_next = flen_reg;
        end else if (cmd.rem_clear) begin
            rem_next = '0;
        end

        case (cmd.op)
            DP_CAPTURE: begin
                neg_next  = raw_neg;
                mag_next  = raw_neg ? (~raw + 1'b1) : raw;
                last_next = s_payload.last_in;
                x_next    = '0;
                if (stat.fade_active) begin
                    div_next  = (rem_reg > flen_reg) ? '0 : (flen_reg - rem_reg);
                    rem_next  = rem_reg - 1'b1;
                end else begin
                    fade_next = FADE_ONE;
                end
            end
            DP_DIV: begin
                div_next = div_ge ? FLEN_W'(div_shl - {1'b0, flen_reg})
                                  : div_shl[FLEN_W-1:0];
                x_next   = {x_reg[X_W-2:0], div_ge};
            end
            DP_SQ: begin
                prod_next = mul_p;
            end
            DP_POLY: begin
                fade_next = mul_p[MUL_A_W +: FADE_W];
            end
            DP_MG: begin
                prod_next = mul_p;
            end
            DP_MF: begin
                prod_next = mul_p;
            end
            DP_OUT: begin
                m_valid_next         = 1'b1;
                m_data_next.last_out = last_reg;
                m_data_next.clipped  = 1'b0;
                if (neg_reg) begin
                    if (r_mag > NEG_LIM) begin
                        m_data_next.sample_out = SMP_MIN;
                        m_data_next.clipped    = 1'b1;
                    end else begin
                        m_data_next.sample_out = SMP_W'(~r_mag + 1'b1);
                    end
                end else begin
                    if (r_mag > POS_LIM) begin
                        m_data_next.sample_out = SMP_MAX;
                        m_data_next.clipped    = 1'b1;
                    end else begin
                        m_data_next.sample_out = r_mag[SMP_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= GAIN_RST;
            flen_reg    <= FLEN_RST;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            gain_reg    <= gain_next;
            flen_reg    <= flen_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        last_reg   <= last_next;
        div_reg    <= div_next;
        x_reg      <= x_next;
        fade_reg   <= fade_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_OUT |-> !stat.out_full)
        else $error("result register overwritten while full");

    a_fade_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_MF |-> fade_reg <= FADE_ONE)
        else $error("fade factor above unity");

endmodule

// File: rtl/core/agsfi_ctrl.sv
// ----------------------------------------------------------------------------
// agsfi_ctrl
// Controller: run/suspend state, event decode and datapath sequencing.
// ----------------------------------------------------------------------------
module agsfi_ctrl import agsfi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  opcode,
    input  agsfi_stat_t stat,
    output agsfi_cmd_t  cmd
);

    agsfi_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             susp_reg, susp_next;
    logic             take;
    logic             live;

    assign take = s_valid && (state_reg == ST_IDLE);
    assign live = run_reg && !susp_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && opcode == OP_SAMPLE && live) begin
                    state_next = stat.fade_active ? ST_DIV : ST_MG;
                end
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_POLY;
            ST_POLY: state_next = ST_MG;
            ST_MG:   state_next = ST_MF;
            ST_MF:   state_next = ST_OUT;
            ST_OUT: begin
                if (!stat.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd.op        = DP_IDLE;
        cmd.rem_load  = 1'b0;
        cmd.rem_clear = 1'b0;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        susp_next     = susp_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (take) begin
                    case (opcode)
                        OP_SAMPLE: begin
                            if (live) begin
                                cmd.op = DP_CAPTURE;
                            end
                        end
                        OP_INIT: begin
                            run_next     = 1'b1;
                            susp_next    = 1'b0;
                            cmd.rem_load = 1'b1;
                        end
                        OP_RESUME: begin
                            if (run_reg) begin
                                susp_next    = 1'b0;
                                cmd.rem_load = 1'b1;
                            end
                        end
                        OP_PAUSE: begin
                            if (run_reg) begin
                                susp_next     = 1'b1;
                                cmd.rem_clear = 1'b1;
                            end
                        end
                        OP_SHUTDOWN: begin
                            run_next  = 1'b0;
                            susp_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                cmd.op   = DP_DIV;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SQ:   cmd.op = DP_SQ;
            ST_POLY: cmd.op = DP_POLY;
            ST_MG:   cmd.op = DP_MG;
            ST_MF:   cmd.op = DP_MF;
            ST_OUT:  cmd.op = stat.out_full ? DP_IDLE : DP_OUT;
            default: cmd.op = DP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            susp_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            susp_reg  <= susp_next;
        end
    end

    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take && opcode == OP_SAMPLE && live
        |=> state_reg == ST_DIV || state_reg == ST_MG)
        else $error("live sample did not start processing");

    a_drop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take && opcode == OP_SAMPLE && !live |=> state_reg == ST_IDLE)
        else $error("dropped sample entered processing");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1) |=> state_reg == ST_SQ)
        else $error("divider overran its step count");

    a_pause: assert property (@(posedge aclk) disable iff (!aresetn)
        take && opcode == OP_PAUSE && run_reg |=> susp_reg && run_reg)
        else $error("pause not applied");

endmodule

// File: bench/tb_audio_gain_smoothstep_fade_in_top.sv
// ----------------------------------------------------------------------------
// tb_audio_gain_smoothstep_fade_in_top
// Self-checking bench for the smoothstep fade-in gain stage.
//
// A tracker follows the run/suspend state, fade count and registers of the
// block and works out each gained, faded, rounded and saturated sample. Each
// result beat is checked against the oldest expected one. A short directed
// sequence covers the control events, dropped samples and the sample
// extremes. Random phases follow, with the gain and fade length changed
// between them, and with the sender idling and the receiver stalling at
// different rates.
// ----------------------------------------------------------------------------
module tb_audio_gain_smoothstep_fade_in_top import agsfi_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          ITEMS_PER_PHASE = 220;
    localparam int          NUM_PHASES      = 8;
    localparam int unsigned MAX_SHOWN       = 40;

    localparam logic [2:0]           OP_RSVD_LO   = 3'd5;
    localparam logic [2:0]           OP_RSVD_HI   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    class fade_gain_tracker;
        logic [GAIN_W-1:0] gain;
        logic [FLEN_W-1:0] fade_len;
        logic [FLEN_W-1:0] fade_rem;
        bit                running;
        bit                suspended;
        agsfi_out_t        expected_samples[$];
        int unsigned       mismatches;

        function new();
            gain       = GAIN_RST;
            fade_len   = FLEN_RST;
            fade_rem   = '0;
            running    = 1'b0;
            suspended  = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            if (idx == REG_GAIN) begin
                gain = value[GAIN_W-1:0];
            end else if (idx == REG_FLEN) begin
                fade_len = value[FLEN_W-1:0];
            end
        endfunction

        function void take_item(agsfi_in_t it);
            longint unsigned  mag;
            longint unsigned  fade;
            longint unsigned  done;
            longint unsigned  x;
            longint unsigned  r;
            logic [SMP_W-1:0] raw;
            agsfi_out_t       beat;
            raw  = it.sample_in;
            beat = '0;
            case (it.opcode)
                OP_INIT: begin
                    running   = 1'b1;
                    suspended = 1'b0;
                    fade_rem  = fade_len;
                end
                OP_RESUME: begin
                    if (running) begin
                        suspended = 1'b0;
                        fade_rem  = fade_len;
                    end
                end
                OP_PAUSE: begin
                    if (running) begin
                        suspended = 1'b1;
                        fade_rem  = '0;
                    end
                end
                OP_SHUTDOWN: begin
                    running   = 1'b0;
                    suspended = 1'b0;
                end
                OP_SAMPLE: begin
                    if (running && !suspended) begin
                        mag  = raw[SMP_W-1] ? 64'd65536 - raw : raw;
                        fade = 64'd65536;
                        if (fade_rem != 0 && fade_len != 0) begin
                            done = (fade_rem > fade_len) ? 64'd0 : fade_len - fade_rem;
                            x    = (done << 16) / fade_len;
                            if (x > 64'd65535) begin
                                x = 64'd65535;
                            end
                            fade_rem = fade_rem - 1'b1;
                            fade     = (x * x * (64'd196608 - 2 * x)) >> 32;
                        end
                        r = (mag * gain * fade + (64'd1 << 23)) >> 24;
                        if (raw[SMP_W-1]) begin
                            beat.clipped = (r > 64'd32768);
                            if (beat.clipped) begin
                                r = 64'd32768;
                            end
                            beat.sample_out = SMP_W'(64'd65536 - r);
                        end else begin
                            beat.clipped = (r > 64'd32767);
                            if (beat.clipped) begin
                                r = 64'd32767;
                            end
                            beat.sample_out = SMP_W'(r);
                        end
                        beat.last_out = it.last_in;
                        expected_samples.push_back(beat);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("mismatch: %s", what);
            end
        endtask

        task check_sample(agsfi_out_t got);
            agsfi_out_t want;
            if (expected_samples.size() == 0) begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            want = expected_samples.pop_front();
            if (got.sample_out !== want.sample_out) begin
                report($sformatf("sample_out %0d, expected %0d",
                                 got.sample_out, want.sample_out));
            end
            if (got.clipped !== want.clipped) begin
                report($sformatf("clipped %b, expected %b", got.clipped, want.clipped));
            end
            if (got.last_out !== want.last_out) begin
                report($sformatf("last_out %b, expected %b", got.last_out, want.last_out));
            end
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    agsfi_in_t            s_payload = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    agsfi_out_t           m_payload;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    fade_gain_tracker sb = new();
    int               src_idle_pct = 0;
    int               snk_stall_pct = 0;
    int               quiet_cycles = 0;

    audio_gain_smoothstep_fade_in_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_sample(m_payload);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL audio_gain_smoothstep_fade_in_top");
            $finish;
        end
    end

    function automatic agsfi_in_t mk(logic [2:0] op, logic signed [SMP_W-1:0] smp,
                                     logic last);
        agsfi_in_t it;
        it.opcode    = op;
        it.sample_in = smp;
        it.last_in   = last;
        return it;
    endfunction

    task automatic send_item(input agsfi_in_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_item(it);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    // hold until every expected beat is back, then let the datapath go quiet
    task automatic settle();
        while (sb.expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        agsfi_in_t              it;
        logic [2:0]             op;
        logic signed [SMP_W-1:0] smp;
        logic [CFG_DAT_W-1:0]   gain_val;
        logic [CFG_DAT_W-1:0]   flen_val;
        int                     done_items;
        int                     pick;
        bit                     ignored;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stopped: drop samples, ignore resume, pause and reserved codes
        send_item(mk(OP_SAMPLE, 16'sd1000, 1'b1));
        send_item(mk(OP_RESUME, '0, 1'b0));
        send_item(mk(OP_PAUSE, '0, 1'b0));
        for (int unsigned k = OP_RSVD_LO; k <= OP_RSVD_HI; k++) begin
            send_item(mk(3'(k), SMP_MIN, 1'b1));
        end
        send_item(mk(OP_SHUTDOWN, '0, 1'b0));

        send_item(mk(OP_INIT, '0, 1'b0));
        send_item(mk(OP_SAMPLE, SMP_MAX, 1'b1));
        send_item(mk(OP_SAMPLE, SMP_MIN, 1'b0));
        send_item(mk(OP_INIT, '0, 1'b0));
        send_item(mk(OP_SAMPLE, 16'sd0, 1'b0));
        send_item(mk(OP_PAUSE, '0, 1'b0));
        send_item(mk(OP_SAMPLE, 16'sd5, 1'b1));
        send_item(mk(OP_RESUME, '0, 1'b0));
        send_item(mk(OP_SAMPLE, -16'sd1, 1'b1));
        send_item(mk(OP_SHUTDOWN, '0, 1'b0));
        send_item(mk(OP_SAMPLE, 16'sd1, 1'b0));

        s_valid <= 1'b0;
        settle();
        cfg_write(REG_GAIN, 16'd4095);
        cfg_write(REG_FLEN, 16'd0);
        cfg_valid <= 1'b0;
        send_item(mk(OP_INIT, '0, 1'b0));
        send_item(mk(OP_SAMPLE, SMP_MAX, 1'b0));
        send_item(mk(OP_SAMPLE, SMP_MIN, 1'b1));
        send_item(mk(OP_SAMPLE, 16'sd1, 1'b0));
        send_item(mk(OP_SAMPLE, -16'sd1, 1'b1));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            s_valid <= 1'b0;
            settle();
            case (phase)
                0: begin gain_val = 16'd768;           flen_val = 16'd8;      end
                1: begin gain_val = 16'd0;             flen_val = 16'd16;     end
                2: begin gain_val = 16'd4095;          flen_val = 16'd1;      end
                3: begin gain_val = 16'($urandom);     flen_val = 16'hFFFF;   end
                4: begin gain_val = 16'd256;           flen_val = 16'd0;      end
                5: begin gain_val = 16'($urandom);     flen_val = 16'($urandom_range(2, 64)); end
                6: begin gain_val = 16'd384;           flen_val = 16'd5;      end
                default: begin
                    gain_val = 16'($urandom);
                    flen_val = 16'($urandom_range(1, 32));
                end
            endcase
            cfg_write(REG_GAIN, gain_val);
            cfg_write(REG_FLEN, flen_val);
            if (phase == NUM_PHASES - 1) begin
                cfg_write(REG_SPARE_LO, 16'($urandom));
                cfg_write(REG_SPARE_HI, 16'($urandom));
            end
            cfg_valid <= 1'b0;

            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 49; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 49; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase

            done_items = 0;
            while (done_items < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (!sb.running && pick < 60) begin
                    op = OP_INIT;
                end else if (sb.suspended && pick < 50) begin
                    op = OP_RESUME;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 86) begin
                        op = OP_SAMPLE;
                    end else if (pick < 89) begin
                        op = OP_INIT;
                    end else if (pick < 92) begin
                        op = OP_RESUME;
                    end else if (pick < 95) begin
                        op = OP_PAUSE;
                    end else if (pick < 97) begin
                        op = OP_SHUTDOWN;
                    end else begin
                        op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    smp = SMP_MAX;
                end else if (pick < 8) begin
                    smp = SMP_MIN;
                end else if (pick < 10) begin
                    smp = 16'sd0;
                end else if (pick < 12) begin
                    smp = -16'sd1;
                end else begin
                    smp = 16'($urandom);
                end
                it      = mk(op, smp, 1'($urandom_range(0, 1)));
                ignored = (op >= OP_RSVD_LO)
                       || (!sb.running && (op == OP_SAMPLE || op == OP_RESUME
                                           || op == OP_PAUSE))
                       || (sb.suspended && op == OP_SAMPLE);
                send_item(it);
                if (!ignored) begin
                    done_items++;
                end
            end
        end

        s_valid <= 1'b0;
        settle();
        if (sb.expected_samples.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.expected_samples.size()));
        end
        if (sb.mismatches == 0) begin
            $display("PASS audio_gain_smoothstep_fade_in_top");
        end else begin
            $display("FAIL audio_gain_smoothstep_fade_in_top");
        end
        $finish;
    end

endmodule
